FILE: hw/rtl/icx_pkg.sv
// ============================================================================
// icx_pkg: shared definitions for the inverse color transform finalize unit
// Field widths, register layout, register indexes and the per-component
// configuration record used by the transform and finalize stages.
// ============================================================================
package icx_pkg;

    // Sample and field widths fixed by the pixel format.
    localparam int IN_W        = 24;
    localparam int OUT_W       = 17;

    // Default fixed-point formats.
    localparam int FRAC_BITS_DEF = 8;
    localparam int COEF_BITS_DEF = 14;

    // Configuration port layout.
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 50;
    localparam int SHIFT_REG_W = 22;
    localparam int RANGE_REG_W = 50;

    // Sub-fields of the shift and range registers.
    localparam int DS_W        = 6;
    localparam int RND_W       = 16;
    localparam int DC_W        = 16;
    localparam int BOUND_W     = 17;
    localparam int RND_LSB     = 6;
    localparam int MIN_LSB     = 16;
    localparam int MAX_LSB     = 33;

    // Range register after reset: dc 0, minimum 0, maximum 255.
    localparam logic [RANGE_REG_W-1:0] RANGE_RST = 50'd2190433320960;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE        = 3'd0,
        CFG_RED_SHIFT   = 3'd1,
        CFG_RED_RANGE   = 3'd2,
        CFG_GREEN_SHIFT = 3'd3,
        CFG_GREEN_RANGE = 3'd4,
        CFG_BLUE_SHIFT  = 3'd5,
        CFG_BLUE_RANGE  = 3'd6
    } t_cfg_idx;

    // Transform selection.
    typedef enum logic {
        MODE_REV   = 1'b0,
        MODE_IRREV = 1'b1
    } t_mode;

    // Per-component finalize settings, unpacked from the shift and range registers.
    typedef struct packed {
        logic [DS_W-1:0]    ds;
        logic [RND_W-1:0]   rnd;
        logic [DC_W-1:0]    dc;
        logic [BOUND_W-1:0] mn;
        logic [BOUND_W-1:0] mx;
    } t_comp_cfg;

endpackage

FILE: hw/rtl/icx_in_if.sv
// ============================================================================
// icx_in_if: input pixel channel
// Valid/ready channel carrying one decoded luma / color-difference pixel.
// ============================================================================
interface icx_in_if
    import icx_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] luma_in;
    logic signed [IN_W-1:0] blue_diff_in;
    logic signed [IN_W-1:0] red_diff_in;
    logic                   row_last_in;

    modport source (
        output valid, luma_in, blue_diff_in, red_diff_in, row_last_in,
        input  ready
    );

    modport sink (
        input  valid, luma_in, blue_diff_in, red_diff_in, row_last_in,
        output ready
    );
endinterface

FILE: hw/rtl/icx_out_if.sv
// ============================================================================
// icx_out_if: output pixel channel
// Valid/ready channel carrying one finalized red/green/blue pixel.
// ============================================================================
interface icx_out_if
    import icx_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] red_out;
    logic signed [OUT_W-1:0] green_out;
    logic signed [OUT_W-1:0] blue_out;
    logic                    row_last_out;

    modport source (
        output valid, red_out, green_out, blue_out, row_last_out,
        input  ready
    );

    modport sink (
        input  valid, red_out, green_out, blue_out, row_last_out,
        output ready
    );
endinterface

FILE: hw/rtl/icx_transform.sv
// ============================================================================
// icx_transform: inverse RCT / ICT core
// Turns one fixed-point Y/Cb/Cr pixel into integer R/G/B components, using
// the reversible integer transform or the Q-format irreversible transform.
// ============================================================================
module icx_transform
    import icx_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int COEF_BITS = COEF_BITS_DEF,
    parameter int COMP_W    = IN_W - FRAC_BITS + 4
) (
    input  t_mode                    i_mode,
    input  logic signed [IN_W-1:0]   i_y,
    input  logic signed [IN_W-1:0]   i_cb,
    input  logic signed [IN_W-1:0]   i_cr,
    output logic signed [COMP_W-1:0] o_r,
    output logic signed [COMP_W-1:0] o_g,
    output logic signed [COMP_W-1:0] o_b
);

    localparam int INT_W = IN_W - FRAC_BITS;
    localparam int KW    = COEF_BITS + 1;
    localparam int P_W   = IN_W + KW + 1;
    localparam int S_W   = IN_W + KW + 3;
    localparam int TSH   = FRAC_BITS + COEF_BITS;

    // Coefficients rounded to COEF_BITS fractional bits.
    localparam longint unsigned KQ_CR_R =
        ((64'd1402000 << COEF_BITS) + 64'd500000) / 64'd1000000;
    localparam longint unsigned KQ_CR_G =
        ((64'd714136 << COEF_BITS) + 64'd500000) / 64'd1000000;
    localparam longint unsigned KQ_CB_G =
        ((64'd344136 << COEF_BITS) + 64'd500000) / 64'd1000000;
    localparam longint unsigned KQ_CB_B =
        ((64'd1772000 << COEF_BITS) + 64'd500000) / 64'd1000000;

    localparam logic signed [KW:0] K_CR_R = (KW+1)'(KQ_CR_R);
    localparam logic signed [KW:0] K_CR_G = (KW+1)'(KQ_CR_G);
    localparam logic signed [KW:0] K_CB_G = (KW+1)'(KQ_CB_G);
    localparam logic signed [KW:0] K_CB_B = (KW+1)'(KQ_CB_B);

    // Masks that turn an arithmetic shift into a shift toward zero.
    localparam logic [IN_W:0]  FMASK = (IN_W+1)'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic [S_W-1:0] TMASK = S_W'((64'd1 << TSH) - 64'd1);

    // Drop the fraction of a sample, rounding toward zero.
    function automatic logic signed [INT_W-1:0] trunc_frac(
        input logic signed [IN_W-1:0] v
    );
        logic signed [IN_W:0] t;
        t = (IN_W+1)'(v) + (v[IN_W-1] ? FMASK : '0);
        return INT_W'(t >>> FRAC_BITS);
    endfunction

    // Drop the fraction of a wide ICT sum, rounding toward zero.
    function automatic logic signed [COMP_W-1:0] trunc_sum(
        input logic signed [S_W-1:0] v
    );
        logic signed [S_W-1:0] t;
        t = v + (v[S_W-1] ? TMASK : '0);
        return COMP_W'(t >>> TSH);
    endfunction

    // Reversible path: integer inverse RCT.
    logic signed [INT_W-1:0] yi;
    logic signed [INT_W-1:0] cbi;
    logic signed [INT_W-1:0] cri;
    logic signed [INT_W:0]   cbcr_sum;
    logic signed [INT_W+1:0] rct_g;
    logic signed [INT_W+2:0] rct_r;
    logic signed [INT_W+2:0] rct_b;

    assign yi       = trunc_frac(i_y);
    assign cbi      = trunc_frac(i_cb);
    assign cri      = trunc_frac(i_cr);
    assign cbcr_sum = (INT_W+1)'(cbi) + (INT_W+1)'(cri);
    assign rct_g    = (INT_W+2)'(yi) - (INT_W+2)'(cbcr_sum >>> 2);
    assign rct_r    = (INT_W+3)'(cri) + (INT_W+3)'(rct_g);
    assign rct_b    = (INT_W+3)'(cbi) + (INT_W+3)'(rct_g);

    // Irreversible path: one product per coefficient, then the sums.
    logic signed [P_W-1:0] p_cr_r;
    logic signed [P_W-1:0] p_cr_g;
    logic signed [P_W-1:0] p_cb_g;
    logic signed [P_W-1:0] p_cb_b;
    logic signed [S_W-1:0] ys;
    logic signed [S_W-1:0] ict_r;
    logic signed [S_W-1:0] ict_g;
    logic signed [S_W-1:0] ict_b;

    assign p_cr_r = P_W'(i_cr) * P_W'(K_CR_R);
    assign p_cr_g = P_W'(i_cr) * P_W'(K_CR_G);
    assign p_cb_g = P_W'(i_cb) * P_W'(K_CB_G);
    assign p_cb_b = P_W'(i_cb) * P_W'(K_CB_B);

    assign ys    = S_W'(i_y) <<< COEF_BITS;
    assign ict_r = ys + S_W'(p_cr_r);
    assign ict_g = ys - S_W'(p_cr_g) - S_W'(p_cb_g);
    assign ict_b = ys + S_W'(p_cb_b);

    // Mode select.
    always_comb begin
        unique case (i_mode)
            MODE_IRREV: begin
                o_r = trunc_sum(ict_r);
                o_g = trunc_sum(ict_g);
                o_b = trunc_sum(ict_b);
            end
            default: begin
                o_r = COMP_W'(rct_r);
                o_g = COMP_W'(rct_g);
                o_b = COMP_W'(rct_b);
            end
        endcase
    end

endmodule

FILE: hw/rtl/icx_finalize.sv
// ============================================================================
// icx_finalize: per-component shift, DC offset and clamp
// Applies the rounded right shift or left shift (irreversible mode only),
// adds the DC offset and clamps to the signed bounds, minimum last.
// ============================================================================
module icx_finalize
    import icx_pkg::*;
#(
    parameter int COMP_W = IN_W - FRAC_BITS_DEF + 4
) (
    input  t_mode                    i_mode,
    input  t_comp_cfg                i_cfg,
    input  logic signed [COMP_W-1:0] i_x,
    output logic signed [OUT_W-1:0]  o_y
);

    localparam int MAX_LSH = 2 ** (DS_W - 1);
    localparam int A_W     = ((COMP_W > RND_W) ? COMP_W : RND_W + 1) + 1;
    localparam int W_W     = COMP_W + MAX_LSH + 1;

    logic signed [DS_W-1:0] ds;
    logic [DS_W-2:0]        amt_r;
    logic [DS_W-1:0]        amt_l;
    logic signed [A_W-1:0]  x_rnd;
    logic signed [A_W-1:0]  x_rsh;
    logic signed [W_W-1:0]  x_lsh;
    logic signed [W_W-1:0]  x_sh;
    logic signed [W_W-1:0]  x_dc;
    logic signed [W_W-1:0]  lo;
    logic signed [W_W-1:0]  hi;
    logic signed [W_W-1:0]  x_cl;

    assign ds    = $signed(i_cfg.ds);
    assign amt_r = ds[DS_W-2:0];
    assign amt_l = DS_W'(-ds);

    // Rounded right shift (floor) and plain left shift.
    assign x_rnd = A_W'(i_x) + A_W'(i_cfg.rnd);
    assign x_rsh = x_rnd >>> amt_r;
    assign x_lsh = W_W'(i_x) <<< amt_l;

    always_comb begin
        priority if (i_mode == MODE_IRREV && ds > 0) begin
            x_sh = W_W'(x_rsh);
        end else if (i_mode == MODE_IRREV && ds < 0) begin
            x_sh = x_lsh;
        end else begin
            x_sh = W_W'(i_x);
        end
    end

    // DC offset, then the upper bound and the lower bound, which wins.
    assign x_dc = x_sh + W_W'(i_cfg.dc);
    assign lo   = W_W'($signed(i_cfg.mn));
    assign hi   = W_W'($signed(i_cfg.mx));

    always_comb begin
        x_cl = x_dc;
        if (x_cl > hi) begin
            x_cl = hi;
        end
        if (x_cl < lo) begin
            x_cl = lo;
        end
    end

    assign o_y = x_cl[OUT_W-1:0];

endmodule

FILE: hw/rtl/inverse_color_transform_finalize_unit.sv
// ============================================================================
// inverse_color_transform_finalize_unit: JPEG 2000 style inverse RCT / ICT
// Converts decoded Y/Cb/Cr pixels to finalized R/G/B samples, with per
// component shift, DC offset and clamp, one pixel per clock when not stalled.
// ============================================================================
//
//  Channel   Dir  Handshake           Payload
//  i_pix     in   valid / ready       luma_in, blue_diff_in, red_diff_in,
//                                     row_last_in
//  o_pix     out  valid / ready       red_out, green_out, blue_out,
//                                     row_last_out
//  i_cfg_*   in   i_cfg_we            i_cfg_idx, i_cfg_data (write only)
//
//  A pixel passes one input register, then the transform and finalize logic
//  into the output register. A pixel is taken every cycle unless the output
//  stalls; then an empty input register takes one more before ready falls.
//  The multiply, sum and finalize path between the two registers sets the
//  clock. Reset clears both valid flags and returns the settings to defaults.
//
module inverse_color_transform_finalize_unit
    import icx_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    icx_in_if.sink                i_pix,
    icx_out_if.source             o_pix
);

    localparam int COMP_W = IN_W - FRAC_BITS + 4;
    localparam int NCOMP  = 3;

    // Configuration registers.
    t_mode                  r_mode;
    logic [SHIFT_REG_W-1:0] r_shift [NCOMP];
    logic [RANGE_REG_W-1:0] r_range [NCOMP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_REV;
            for (int c = 0; c < NCOMP; c++) begin
                r_shift[c] <= '0;
                r_range[c] <= RANGE_RST;
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:        r_mode     <= t_mode'(i_cfg_data[0]);
                CFG_RED_SHIFT:   r_shift[0] <= i_cfg_data[SHIFT_REG_W-1:0];
                CFG_RED_RANGE:   r_range[0] <= i_cfg_data[RANGE_REG_W-1:0];
                CFG_GREEN_SHIFT: r_shift[1] <= i_cfg_data[SHIFT_REG_W-1:0];
                CFG_GREEN_RANGE: r_range[1] <= i_cfg_data[RANGE_REG_W-1:0];
                CFG_BLUE_SHIFT:  r_shift[2] <= i_cfg_data[SHIFT_REG_W-1:0];
                CFG_BLUE_RANGE:  r_range[2] <= i_cfg_data[RANGE_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the per-component settings.
    t_comp_cfg comp_cfg [NCOMP];

    always_comb begin
        for (int c = 0; c < NCOMP; c++) begin
            comp_cfg[c].ds  = r_shift[c][DS_W-1:0];
            comp_cfg[c].rnd = r_shift[c][RND_LSB +: RND_W];
            comp_cfg[c].dc  = r_range[c][DC_W-1:0];
            comp_cfg[c].mn  = r_range[c][MIN_LSB +: BOUND_W];
            comp_cfg[c].mx  = r_range[c][MAX_LSB +: BOUND_W];
        end
    end

    // Handshake: the input register moves on whenever the output register
    // is empty or being drained.
    logic r_s1_vld;
    logic r_out_vld;
    logic out_free;
    logic s1_move;
    logic in_take;

    assign out_free    = !r_out_vld || o_pix.ready;
    assign s1_move     = r_s1_vld && out_free;
    assign i_pix.ready = !r_s1_vld || out_free;
    assign in_take     = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_pix.ready) begin
                r_s1_vld <= i_pix.valid;
            end
            if (out_free) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    // Input register.
    logic signed [IN_W-1:0] r_s1_y;
    logic signed [IN_W-1:0] r_s1_cb;
    logic signed [IN_W-1:0] r_s1_cr;
    logic                   r_s1_last;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_y    <= i_pix.luma_in;
            r_s1_cb   <= i_pix.blue_diff_in;
            r_s1_cr   <= i_pix.red_diff_in;
            r_s1_last <= i_pix.row_last_in;
        end
    end

    // Transform and per-component finalize.
    logic signed [COMP_W-1:0] comp_x [NCOMP];
    logic signed [OUT_W-1:0]  n_comp [NCOMP];

    icx_transform #(
        .FRAC_BITS (FRAC_BITS),
        .COEF_BITS (COEF_BITS),
        .COMP_W    (COMP_W)
    ) u_transform (
        .i_mode (r_mode),
        .i_y    (r_s1_y),
        .i_cb   (r_s1_cb),
        .i_cr   (r_s1_cr),
        .o_r    (comp_x[0]),
        .o_g    (comp_x[1]),
        .o_b    (comp_x[2])
    );

    for (genvar c = 0; c < NCOMP; c++) begin : g_fin
        icx_finalize #(
            .COMP_W (COMP_W)
        ) u_finalize (
            .i_mode (r_mode),
            .i_cfg  (comp_cfg[c]),
            .i_x    (comp_x[c]),
            .o_y    (n_comp[c])
        );
    end

    // Output register.
    logic signed [OUT_W-1:0] r_out_comp [NCOMP];
    logic                    r_out_last;

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            for (int c = 0; c < NCOMP; c++) begin
                r_out_comp[c] <= n_comp[c];
            end
            r_out_last <= r_s1_last;
        end
    end

    assign o_pix.valid        = r_out_vld;
    assign o_pix.red_out      = r_out_comp[0];
    assign o_pix.green_out    = r_out_comp[1];
    assign o_pix.blue_out     = r_out_comp[2];
    assign o_pix.row_last_out = r_out_last;

endmodule

FILE: hw/rtl/icx_checker.sv
// ============================================================================
// icx_checker: port-level checks for the inverse color transform unit
// Watches the pixel channels for reset behavior, flow and latency.
// ============================================================================
module icx_checker
    import icx_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [OUT_W-1:0] i_out_red,
    input logic [OUT_W-1:0] i_out_green,
    input logic [OUT_W-1:0] i_out_blue,
    input logic             i_out_last
);

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // An empty output register always lets a pixel in.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output empty");

    // Once an accepted pixel has passed the input and output registers, output valid is high.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |-> ##2 i_out_valid)
        else $error("accepted pixel did not reach the output");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid &&
             $stable({i_out_red, i_out_green, i_out_blue, i_out_last})))
        else $error("stalled output changed");

endmodule

bind inverse_color_transform_finalize_unit icx_checker u_icx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_red   (o_pix.red_out),
    .i_out_green (o_pix.green_out),
    .i_out_blue  (o_pix.blue_out),
    .i_out_last  (o_pix.row_last_out)
);

FILE: verif/inverse_color_transform_finalize_unit_tb.sv
// ============================================================================
// inverse_color_transform_finalize_unit_tb: self-checking pixel stream bench
// Streams Y/Cb/Cr pixels through the unit under several register settings in
// both transform modes. A local model predicts each finalized R/G/B pixel and
// the output stream is compared in order. Both channels idle at random, and
// the output once holds off long enough to back up the input.
// ============================================================================
module inverse_color_transform_finalize_unit_tb;
    import icx_pkg::*;

    // Pixel as offered on the input channel.
    typedef struct packed {
        logic signed [IN_W-1:0] y;
        logic signed [IN_W-1:0] cb;
        logic signed [IN_W-1:0] cr;
        logic                   last;
    } t_pixel;

    // Finalized pixel as seen on the output channel.
    typedef struct packed {
        logic signed [OUT_W-1:0] r;
        logic signed [OUT_W-1:0] g;
        logic signed [OUT_W-1:0] b;
        logic                    last;
    } t_rgb;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int COEF = COEF_BITS_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int ITEMS_PER_PHASE = 72;
    localparam int NUM_PHASES = 9;
    localparam int HOLD_AT_RESULT = 300;
    localparam int HOLD_CYCLES = 160;
    localparam int MAX_REPORTS = 40;

    // Index that decodes to no register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    localparam logic signed [IN_W-1:0] IN_MAX = 24'sh7FFFFF;
    localparam logic signed [IN_W-1:0] IN_MIN = 24'sh800000;
    localparam logic signed [BOUND_W-1:0] BOUND_MAX = 17'sh0FFFF;
    localparam logic signed [BOUND_W-1:0] BOUND_MIN = 17'sh10000;

    // Inverse ICT coefficients rounded to COEF fractional bits.
    localparam longint K_CR_R = ((longint'(1402000) <<< COEF) + 500000) / 1000000;
    localparam longint K_CR_G = ((longint'(714136) <<< COEF) + 500000) / 1000000;
    localparam longint K_CB_G = ((longint'(344136) <<< COEF) + 500000) / 1000000;
    localparam longint K_CB_B = ((longint'(1772000) <<< COEF) + 500000) / 1000000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    icx_in_if  pix_in ();
    icx_out_if pix_out ();

    inverse_color_transform_finalize_unit uut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_pix     (pix_in),
        .o_pix     (pix_out)
    );

    // Local copy of the register file.
    t_mode                  cfg_mode;
    logic [SHIFT_REG_W-1:0] shift_q [3];
    logic [RANGE_REG_W-1:0] range_q [3];

    t_pixel pending_pix [$];
    t_rgb   expected_rgb [$];
    t_pixel offered;

    int  err_count;
    int  cycles;
    int  out_count;
    int  gap_left;
    int  stall_left;
    int  hold_left;
    bit  hold_done;
    bit  quiet;

    // Clock.
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic longint shr_to_zero(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-v) >>> s);
    endfunction

    // Rounded right shift or plain left shift of one component.
    function automatic longint scale_comp(longint x, int c);
        logic signed [DS_W-1:0] ds;
        longint rnd;
        int n;
        ds = shift_q[c][DS_W-1:0];
        rnd = longint'(shift_q[c][RND_LSB +: RND_W]);
        n = ds;
        if (n > 0) return (x + rnd) >>> n;
        if (n < 0) return x * (longint'(1) <<< (-n));
        return x;
    endfunction

    // DC offset, then upper bound, then lower bound (which wins if inverted).
    function automatic logic signed [OUT_W-1:0] clamp_comp(longint x, int c);
        logic signed [BOUND_W-1:0] lo;
        logic signed [BOUND_W-1:0] hi;
        longint v;
        lo = range_q[c][MIN_LSB +: BOUND_W];
        hi = range_q[c][MAX_LSB +: BOUND_W];
        v = x + longint'(range_q[c][DC_W-1:0]);
        if (v > longint'(hi)) v = longint'(hi);
        if (v < longint'(lo)) v = longint'(lo);
        return v[OUT_W-1:0];
    endfunction

    function automatic t_rgb predict_rgb(t_pixel p);
        t_rgb   res;
        longint yv;
        longint cbv;
        longint crv;
        longint rv;
        longint gv;
        longint bv;
        yv = longint'(p.y);
        cbv = longint'(p.cb);
        crv = longint'(p.cr);
        if (cfg_mode == MODE_REV) begin
            yv = shr_to_zero(yv, FRAC);
            cbv = shr_to_zero(cbv, FRAC);
            crv = shr_to_zero(crv, FRAC);
            gv = yv - ((cbv + crv) >>> 2);
            res.r = clamp_comp(crv + gv, 0);
            res.g = clamp_comp(gv, 1);
            res.b = clamp_comp(cbv + gv, 2);
        end else begin
            yv = yv * (longint'(1) <<< COEF);
            rv = shr_to_zero(yv + crv * K_CR_R, FRAC + COEF);
            gv = shr_to_zero(yv - crv * K_CR_G - cbv * K_CB_G, FRAC + COEF);
            bv = shr_to_zero(yv + cbv * K_CB_B, FRAC + COEF);
            res.r = clamp_comp(scale_comp(rv, 0), 0);
            res.g = clamp_comp(scale_comp(gv, 1), 1);
            res.b = clamp_comp(scale_comp(bv, 2), 2);
        end
        res.last = p.last;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: offers queued pixels, with random gaps.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            pix_in.valid <= 1'b0;
            gap_left = 0;
        end else begin
            // A completed transaction yields one predicted pixel.
            if (pix_in.valid && pix_in.ready)
                expected_rgb.push_back(predict_rgb(offered));

            if (pix_in.valid && !pix_in.ready) begin
                // Keep offering the same pixel until it is taken.
            end else if (gap_left > 0) begin
                gap_left--;
                pix_in.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(1, 18) - 1;
                pix_in.valid <= 1'b0;
            end else if (pending_pix.size() != 0) begin
                offered = pending_pix.pop_front();
                pix_in.luma_in      <= offered.y;
                pix_in.blue_diff_in <= offered.cb;
                pix_in.red_diff_in  <= offered.cr;
                pix_in.row_last_in  <= offered.last;
                pix_in.valid        <= 1'b1;
            end else begin
                pix_in.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: checks each pixel and throttles ready.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_rgb got;
        t_rgb want;
        if (!rst_n) begin
            pix_out.ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end else begin
            if (pix_out.valid && pix_out.ready) begin
                got.r = pix_out.red_out;
                got.g = pix_out.green_out;
                got.b = pix_out.blue_out;
                got.last = pix_out.row_last_out;
                out_count++;
                if (expected_rgb.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: unexpected pixel: actual R %0d G %0d B %0d last %0b",
                                 $time, got.r, got.g, got.b, got.last);
                end else begin
                    want = expected_rgb.pop_front();
                    if (got.r !== want.r || got.g !== want.g || got.b !== want.b ||
                        got.last !== want.last) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch: expected R %0d G %0d B %0d last %0b",
                                     $time, want.r, want.g, want.b, want.last);
                            $display("%0t: mismatch: actual   R %0d G %0d B %0d last %0b",
                                     $time, got.r, got.g, got.b, got.last);
                        end
                    end
                end
            end

            // One long hold-off so the pipeline fills and stalls its input.
            if (!hold_done && out_count >= HOLD_AT_RESULT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end

            if (hold_left > 0) begin
                hold_left--;
                pix_out.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pix_out.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                pix_out.ready <= 1'b0;
            end else begin
                pix_out.ready <= 1'b1;
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d pixels still expected", $time,
                     expected_rgb.size());
            $display("** inverse_color_transform_finalize_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:        cfg_mode = t_mode'(data[0]);
            CFG_RED_SHIFT:   shift_q[0] = data[SHIFT_REG_W-1:0];
            CFG_RED_RANGE:   range_q[0] = data[RANGE_REG_W-1:0];
            CFG_GREEN_SHIFT: shift_q[1] = data[SHIFT_REG_W-1:0];
            CFG_GREEN_RANGE: range_q[1] = data[RANGE_REG_W-1:0];
            CFG_BLUE_SHIFT:  shift_q[2] = data[SHIFT_REG_W-1:0];
            CFG_BLUE_RANGE:  range_q[2] = data[RANGE_REG_W-1:0];
            default: ;
        endcase
    endtask

    // Writes the shift and range registers of one component.
    task automatic write_comp(int c, logic [CFG_DATA_W-1:0] sh, logic [CFG_DATA_W-1:0] rg);
        case (c)
            0: begin
                write_reg(CFG_RED_SHIFT, sh);
                write_reg(CFG_RED_RANGE, rg);
            end
            1: begin
                write_reg(CFG_GREEN_SHIFT, sh);
                write_reg(CFG_GREEN_RANGE, rg);
            end
            default: begin
                write_reg(CFG_BLUE_SHIFT, sh);
                write_reg(CFG_BLUE_RANGE, rg);
            end
        endcase
    endtask

    function automatic logic [CFG_DATA_W-1:0] shift_word(int ds, int rnd);
        logic [DS_W-1:0]  dsf;
        logic [RND_W-1:0] rf;
        dsf = ds[DS_W-1:0];
        rf = rnd[RND_W-1:0];
        return CFG_DATA_W'({rf, dsf});
    endfunction

    function automatic logic [CFG_DATA_W-1:0] range_word(int dc, int lo, int hi);
        logic [DC_W-1:0]    dcf;
        logic [BOUND_W-1:0] lof;
        logic [BOUND_W-1:0] hif;
        dcf = dc[DC_W-1:0];
        lof = lo[BOUND_W-1:0];
        hif = hi[BOUND_W-1:0];
        return {hif, lof, dcf};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[CFG_DATA_W-1:0];
    endfunction

    // Mix of full-range samples and samples whose integer part stays in view.
    function automatic logic signed [IN_W-1:0] rand_sample();
        int v;
        case ($urandom_range(0, 3))
            0:       v = $urandom;
            1:       v = int'($urandom_range(0, 131071)) - 65536;
            2:       v = int'($urandom_range(0, 2097151)) - 1048576;
            default: v = int'($urandom_range(0, 8191)) - 4096;
        endcase
        return v[IN_W-1:0];
    endfunction

    task automatic add_pix(logic signed [IN_W-1:0] y, logic signed [IN_W-1:0] cb,
                           logic signed [IN_W-1:0] cr, logic last);
        t_pixel p;
        p.y = y;
        p.cb = cb;
        p.cr = cr;
        p.last = last;
        pending_pix.push_back(p);
    endtask

    // Waits until every queued pixel has come back and the pipeline is empty.
    // Checked at the falling edge, after the driver's updates have settled.
    task automatic drain();
        while (pending_pix.size() != 0 || expected_rgb.size() != 0 || pix_in.valid)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register settings for one random phase.
    task automatic configure_phase(int ph);
        int c;
        int lo;
        int dc;
        case (ph)
            0: begin
                // Reversible with nonzero shift settings, which must have no effect.
                write_reg(CFG_MODE, CFG_DATA_W'(MODE_REV));
                for (c = 0; c < 3; c++)
                    write_comp(c, rand_word(), range_word(0, BOUND_MIN, BOUND_MAX));
            end
            1: begin
                write_reg(CFG_MODE, CFG_DATA_W'(MODE_IRREV));
                for (c = 0; c < 3; c++)
                    write_comp(c, shift_word(31, 65535),
                               range_word(65535, BOUND_MIN, BOUND_MAX));
            end
            2: begin
                write_reg(CFG_MODE, CFG_DATA_W'(MODE_IRREV));
                for (c = 0; c < 3; c++)
                    write_comp(c, shift_word(-32, $urandom),
                               range_word(0, BOUND_MIN, BOUND_MAX));
            end
            3, 4: begin
                // Minimum above maximum.
                write_reg(CFG_MODE, (ph == 3) ? CFG_DATA_W'(MODE_REV) : CFG_DATA_W'(MODE_IRREV));
                for (c = 0; c < 3; c++) begin
                    lo = $urandom_range(0, 1000);
                    write_comp(c, shift_word(int'($urandom_range(0, 9)) - 3, $urandom),
                               range_word($urandom_range(0, 300), lo,
                                          lo - int'($urandom_range(1, 1000))));
                end
            end
            5, 6: begin
                write_reg(CFG_MODE, rand_word());
                for (c = 0; c < 3; c++)
                    write_comp(c, rand_word(), rand_word());
            end
            7: begin
                write_reg(CFG_MODE, CFG_DATA_W'(MODE_IRREV));
                for (c = 0; c < 3; c++) begin
                    dc = $urandom_range(0, 512);
                    write_comp(c, shift_word(int'($urandom_range(0, 9)) - 3, $urandom),
                               range_word(dc, BOUND_MIN, BOUND_MAX));
                end
            end
            default: begin
                write_reg(CFG_MODE, CFG_DATA_W'(MODE_REV));
                for (c = 0; c < 3; c++)
                    write_comp(c, shift_word(0, 0),
                               range_word($urandom_range(0, 65535), BOUND_MIN, BOUND_MAX));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int ph;
        int k;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        pix_in.valid = 1'b0;
        pix_in.luma_in = '0;
        pix_in.blue_diff_in = '0;
        pix_in.red_diff_in = '0;
        pix_in.row_last_in = 1'b0;
        pix_out.ready = 1'b0;
        err_count = 0;
        cycles = 0;
        out_count = 0;
        hold_done = 1'b0;
        quiet = 1'b0;

        // Settings after reset.
        cfg_mode = MODE_REV;
        for (k = 0; k < 3; k++) begin
            shift_q[k] = '0;
            range_q[k] = RANGE_RST;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reversible mode with the reset clamp of 0..255.
        add_pix(0, 0, 0, 1'b0);
        add_pix(IN_MAX, IN_MAX, IN_MAX, 1'b1);
        add_pix(IN_MIN, IN_MIN, IN_MIN, 1'b0);
        add_pix(IN_MAX, IN_MIN, IN_MAX, 1'b0);
        add_pix(IN_MIN, IN_MAX, IN_MIN, 1'b1);
        // Negative fractions truncate toward zero.
        add_pix(-1, -1, -1, 1'b0);
        add_pix(-255, 255, -256, 1'b0);
        add_pix(100 * 256, 20 * 256, -30 * 256, 1'b0);
        add_pix(300 * 256, 0, 0, 1'b1);
        add_pix(24'sh000180, -24'sh000180, 24'sh7F0000, 1'b0);
        drain();

        // Irreversible mode: no shift, rounded right shift, left shift.
        write_reg(CFG_UNUSED_IDX, rand_word());
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_IRREV));
        write_comp(0, shift_word(0, 16'h1234), range_word(0, BOUND_MIN, BOUND_MAX));
        write_comp(1, shift_word(3, 4), range_word(0, BOUND_MIN, BOUND_MAX));
        write_comp(2, shift_word(-2, 16'hFFFF), range_word(128, BOUND_MIN, BOUND_MAX));
        add_pix(0, 0, 0, 1'b0);
        add_pix(IN_MAX, IN_MAX, IN_MAX, 1'b1);
        add_pix(IN_MIN, IN_MIN, IN_MIN, 1'b0);
        add_pix(128 * 256, 0, 0, 1'b0);
        add_pix(0, 1000 * 256, 0, 1'b0);
        add_pix(0, 0, -1000 * 256, 1'b1);
        add_pix(-1, -1, -1, 1'b0);
        add_pix(IN_MAX, 0, 0, 1'b0);
        add_pix(IN_MIN, 0, 0, 1'b0);
        add_pix(0, IN_MAX, IN_MIN, 1'b1);
        add_pix(100 * 256, -50 * 256, 70 * 256, 1'b0);
        add_pix(-77 * 256 - 13, 33 * 256 + 200, -5 * 256 - 1, 1'b0);
        drain();

        // Random phases, each under its own settings; the last one without idling.
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            configure_phase(ph);
            if (ph == NUM_PHASES - 1)
                quiet = 1'b1;
            for (k = 0; k < ITEMS_PER_PHASE; k++)
                add_pix(rand_sample(), rand_sample(), rand_sample(),
                        ($urandom_range(0, 7) == 0));
            drain();
        end

        repeat (8) @(posedge clk);
        if (err_count == 0 && expected_rgb.size() == 0) begin
            $display("** inverse_color_transform_finalize_unit: PASSED **");
        end else begin
            $display("** inverse_color_transform_finalize_unit: FAILED **");
        end
        $finish;
    end

endmodule

FILE: inverse_color_transform_finalize_unit.f
hw/rtl/icx_pkg.sv
hw/rtl/icx_in_if.sv
hw/rtl/icx_out_if.sv
hw/rtl/icx_transform.sv
hw/rtl/icx_finalize.sv
hw/rtl/inverse_color_transform_finalize_unit.sv
hw/rtl/icx_checker.sv
verif/inverse_color_transform_finalize_unit_tb.sv
